/* rtl/core/stepper_step_profile_model_macros.svh */
// Assertion macros shared by the stepper step-profile RTL.
`ifndef STEPPER_STEP_PROFILE_MODEL_MACROS_SVH
`define STEPPER_STEP_PROFILE_MODEL_MACROS_SVH
`ifndef NO_ASSERTIONS
// Generic clocked assertion with an explicit clock and active-low reset.
`define SSP_ASSERT_CLK(lbl, clk_s, rstn_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
        else $error("stepper step profile: assertion failed");
// Assertion on the block clock and reset.
`define SSP_ASSERT(lbl, prop) `SSP_ASSERT_CLK(lbl, clk, rst_n, prop)
`else
`define SSP_ASSERT_CLK(lbl, clk_s, rstn_s, prop)
`define SSP_ASSERT(lbl, prop)
`endif
`endif

/* rtl/core/ssp_pkg.sv */
// Types and constants of the stepper step-profile model.
`default_nettype none
package ssp_pkg;

    // Sequencer states, one-hot.
    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_PREP  = 8'b0000_0010,
        ST_CLASS = 8'b0000_0100,
        ST_MUL   = 8'b0000_1000,
        ST_RND   = 8'b0001_0000,
        ST_DIV   = 8'b0010_0000,
        ST_NEXT  = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

    // Operation steps run on the shared add/subtract unit.
    typedef enum logic [3:0] {
        STP_DD   = 4'd0,
        STP_MM   = 4'd1,
        STP_NA   = 4'd2,
        STP_ANG  = 4'd3,
        STP_SM   = 4'd4,
        STP_NR   = 4'd5,
        STP_RATE = 4'd6,
        STP_POS  = 4'd7,
        STP_ACD  = 4'd8,
        STP_ACN  = 4'd9,
        STP_ACL  = 4'd10
    } step_t;

    // Configuration register indexes.
    localparam logic [1:0] REG_STEP_ANGLE    = 2'd0;
    localparam logic [1:0] REG_STEP_DURATION = 2'd1;
    localparam logic [1:0] REG_START_ANGLE   = 2'd2;

    // Reset values of the registers.
    localparam logic [30:0] STEP_ANGLE_RST    = 31'd26353589;
    localparam logic [31:0] STEP_DURATION_RST = 32'd1000000000;
    localparam logic [31:0] ACCEL_LIMIT_RST   = 32'd25736;

    // Minus 10 us, the half and end point tolerance, as 48 bit two's complement.
    localparam logic [47:0] NEG_TOL_NS = 48'hFFFF_FFFF_D8F0;

    localparam logic [63:0] NS_PER_S  = 64'd1000000000;
    localparam logic [63:0] E18       = 64'd1000000000000000000;
    localparam logic [31:0] SAT31     = 32'h7FFF_FFFF;

endpackage
`default_nettype wire

/* rtl/core/stepper_step_profile_model.sv */
// Top level of the stepper step-profile model: sequencer around one shared adder.
// An idle tick goes from accept through the output state to its output beat and then takes
// the next beat in idle; a tick that only completes a step goes through prepare, classify and output.
// A moving tick runs five shift-add multiplies and two 128-step restoring divides on one
// 129 bit adder before its output beat; an output stall holds any tick in the output state.
// A config write queues a background recompute, with a position divide for a start
// angle, during which no item is taken. Reset is asynchronous, active low.
`default_nettype none
`include "stepper_step_profile_model_macros.svh"
module stepper_step_profile_model (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [63:0]  s_tdata,   // time_ns[47:0], steps_requested[63:48]
    input  wire logic         s_tuser,   // new_command
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [167:0]      m_tdata,   // angle, rate, accel, steps_target,
                                         // steps_done, position, moving, zero pad
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_addr,
    input  wire logic [31:0]  cfg_data
);

    ssp_pkg::state_t state_reg, state_next;
    ssp_pkg::step_t  step_reg, step_next;

    logic [30:0] step_angle_reg, step_angle_next;
    logic [31:0] step_duration_reg, step_duration_next;
    logic [31:0] cur_angle_reg, cur_angle_next;
    logic [31:0] cur_rate_reg, cur_rate_next;
    logic [31:0] cur_accel_reg, cur_accel_next;
    logic [31:0] accel_limit_reg, accel_limit_next;
    logic [31:0] seg_base_reg, seg_base_next;
    logic [31:0] from_reg, from_next;
    logic [31:0] to_reg, to_next;
    logic [47:0] start_time_reg, start_time_next;
    logic [47:0] mid_time_reg, mid_time_next;
    logic [47:0] end_time_reg, end_time_next;
    logic [15:0] cmd_reg, cmd_next;
    logic [15:0] done_reg, done_next;
    logic [31:0] abs_pos_reg, abs_pos_next;
    logic        f_act_reg, f_act_next;
    logic        f_step_reg, f_step_next;
    logic        f_new_reg, f_new_next;
    logic        f_intr_reg, f_intr_next;
    logic        moving_reg, moving_next;
    logic        pend_pos_reg, pend_pos_next;
    logic        pend_acc_reg, pend_acc_next;
    logic        m_tvalid_reg, m_tvalid_next;

    // Working registers, no reset needed.
    logic [167:0] out_reg, out_next;
    logic [47:0]  t_reg, t_next;
    logic         up_reg, up_next;
    logic         neg_reg, neg_next;
    logic         half2_reg, half2_next;
    logic [31:0]  sl_reg, sl_next;
    logic [47:0]  dl_reg, dl_next;
    logic [47:0]  mag_reg, mag_next;
    logic [95:0]  dd_reg, dd_next;
    logic [31:0]  ang_reg, ang_next;
    logic [31:0]  pos_start_reg, pos_start_next;
    logic [30:0]  pos_sa_reg, pos_sa_next;
    logic [127:0] x_reg, x_next;
    logic [63:0]  y_reg, y_next;
    logic [127:0] z_reg, z_next;
    logic [127:0] w_reg, w_next;
    logic [6:0]   cnt_reg, cnt_next;

    // Shared add/subtract unit.
    logic [127:0] add_p, add_q, rsh;
    logic         add_sub;
    logic [128:0] add_sum;

    // Intermediate values of the item logic.
    logic        s_accept;
    logic        fa, fs, fn, fi;
    logic [15:0] cmd_v, done_v;
    logic [31:0] dur1;
    logic [32:0] dur_half;
    logic signed [47:0] from_prod;
    logic [31:0] from_v;
    logic [31:0] diff;
    logic        up_v;
    logic [47:0] dl_v, dm, de, dt1;
    logic [31:0] ang_q, rate_q, pos_mag;
    logic [34:0] pos_num;

    assign s_accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == ssp_pkg::ST_IDLE) && !pend_pos_reg && !pend_acc_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

    // Operand selection for the shared adder.
    assign rsh = {z_reg[126:0], x_reg[127]};
    always_comb
    begin
        case (state_reg)
            ssp_pkg::ST_DIV:
            begin
                add_p = rsh;
                add_q = w_reg;
                add_sub = 1'b1;
            end
            ssp_pkg::ST_RND:
            begin
                add_p = x_reg;
                add_q = {1'b0, w_reg[127:1]};
                add_sub = 1'b0;
            end
            default:
            begin
                add_p = z_reg;
                add_q = x_reg;
                add_sub = 1'b0;
            end
        endcase
        add_sum = {1'b0, add_p} + {1'b0, (add_sub ? ~add_q : add_q)} + {128'd0, add_sub};
    end

    // Step geometry and tick classification.
    assign dur1      = (step_duration_reg == 32'd0) ? 32'd1 : step_duration_reg;
    assign dur_half  = ({1'b0, dur1} + 33'd1) >> 1;
    assign from_prod = $signed(done_reg) * $signed({1'b0, step_angle_reg});
    assign from_v    = seg_base_reg + from_prod[31:0];
    assign diff      = to_reg - from_reg;
    assign up_v      = !diff[31] && (diff != 32'd0);
    assign dl_v      = (end_time_reg - start_time_reg == 48'd0) ? 48'd1
                                                                : end_time_reg - start_time_reg;
    assign dm        = t_reg - mid_time_reg;
    assign de        = t_reg - end_time_reg;
    assign dt1       = t_reg - start_time_reg;
    assign ang_q     = x_reg[31:0];
    assign rate_q    = (x_reg[127:31] != 97'd0) ? ssp_pkg::SAT31 : x_reg[31:0];
    assign pos_mag   = pos_start_reg[31] ? (32'd0 - pos_start_reg) : pos_start_reg;
    assign pos_num   = {2'b00, pos_mag, 1'b0} + {4'd0, pos_sa_reg};

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        step_angle_next = step_angle_reg;
        step_duration_next = step_duration_reg;
        cur_angle_next = cur_angle_reg;
        cur_rate_next = cur_rate_reg;
        cur_accel_next = cur_accel_reg;
        accel_limit_next = accel_limit_reg;
        seg_base_next = seg_base_reg;
        from_next = from_reg;
        to_next = to_reg;
        start_time_next = start_time_reg;
        mid_time_next = mid_time_reg;
        end_time_next = end_time_reg;
        cmd_next = cmd_reg;
        done_next = done_reg;
        abs_pos_next = abs_pos_reg;
        f_act_next = f_act_reg;
        f_step_next = f_step_reg;
        f_new_next = f_new_reg;
        f_intr_next = f_intr_reg;
        moving_next = moving_reg;
        pend_pos_next = pend_pos_reg;
        pend_acc_next = pend_acc_reg;
        m_tvalid_next = m_tvalid_reg;
        out_next = out_reg;
        t_next = t_reg;
        up_next = up_reg;
        neg_next = neg_reg;
        half2_next = half2_reg;
        sl_next = sl_reg;
        dl_next = dl_reg;
        mag_next = mag_reg;
        dd_next = dd_reg;
        ang_next = ang_reg;
        pos_start_next = pos_start_reg;
        pos_sa_next = pos_sa_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        w_next = w_reg;
        cnt_next = cnt_reg;
        fa = f_act_reg;
        fs = f_step_reg;
        fn = f_new_reg;
        fi = f_intr_reg;
        cmd_v = cmd_reg;
        done_v = done_reg;

        // The output beat leaves when taken.
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ssp_pkg::ST_IDLE:
            begin
                if (s_accept)
                begin
                    t_next = s_tdata[47:0];
                    if (s_tuser)
                    begin
                        cmd_v = s_tdata[63:48];
                        fn = 1'b1;
                        fi = !fa;
                        if (cmd_v == 16'd0)
                        begin
                            fa = 1'b1;
                            done_v = 16'd0;
                        end
                        else
                        begin
                            fa = 1'b0;
                        end
                    end
                    if (!fa)
                    begin
                        if ((fn && !fi) || (fi && fs))
                        begin
                            done_v = 16'd0;
                            seg_base_next = cur_angle_reg;
                            fn = 1'b0;
                            fi = 1'b0;
                        end
                        moving_next = 1'b1;
                        state_next = ssp_pkg::ST_PREP;
                    end
                    else
                    begin
                        start_time_next = s_tdata[47:0];
                        cur_accel_next = 32'd0;
                        moving_next = 1'b0;
                        state_next = ssp_pkg::ST_OUT;
                    end
                    f_act_next = fa;
                    f_new_next = fn;
                    f_intr_next = fi;
                    cmd_next = cmd_v;
                    done_next = done_v;
                end
                else if (pend_pos_reg)
                begin
                    // Start angle preset: round |start| / step angle.
                    pend_pos_next = 1'b0;
                    if (pos_sa_reg == 31'd0)
                    begin
                        abs_pos_next = 32'd0;
                    end
                    else
                    begin
                        neg_next = pos_start_reg[31];
                        x_next = {93'd0, pos_num};
                        w_next = {96'd0, pos_sa_reg, 1'b0};
                        z_next = 128'd0;
                        cnt_next = 7'h7F;
                        step_next = ssp_pkg::STP_POS;
                        state_next = ssp_pkg::ST_DIV;
                    end
                end
                else if (pend_acc_reg)
                begin
                    // Acceleration limit recompute starts with the squared duration.
                    pend_acc_next = 1'b0;
                    x_next = {96'd0, dur1};
                    y_next = {32'd0, dur1};
                    z_next = 128'd0;
                    step_next = ssp_pkg::STP_ACD;
                    state_next = ssp_pkg::ST_MUL;
                end
            end

            ssp_pkg::ST_PREP:
            begin
                // A new step latches its timing and its end angles.
                if (f_step_reg)
                begin
                    f_step_next = 1'b0;
                    end_time_next = start_time_reg + {16'd0, dur1};
                    mid_time_next = start_time_reg + {15'd0, dur_half};
                    from_next = from_v;
                    to_next = (cmd_reg != 16'd0 && !cmd_reg[15])
                              ? from_v + {1'b0, step_angle_reg}
                              : from_v - {1'b0, step_angle_reg};
                end
                state_next = ssp_pkg::ST_CLASS;
            end

            ssp_pkg::ST_CLASS:
            begin
                up_next = up_v;
                sl_next = diff[31] ? (32'd0 - diff) : diff;
                dl_next = dl_v;
                if ($signed(dm) < $signed(ssp_pkg::NEG_TOL_NS))
                begin
                    half2_next = 1'b0;
                    mag_next = dt1[47] ? (48'd0 - dt1) : dt1;
                    cur_accel_next = up_v ? accel_limit_reg : 32'd0 - accel_limit_reg;
                    neg_next = up_v ? dt1[47] : (!dt1[47] && dt1 != 48'd0);
                    x_next = {80'd0, dl_v};
                    y_next = {16'd0, dl_v};
                    z_next = 128'd0;
                    step_next = ssp_pkg::STP_DD;
                    state_next = ssp_pkg::ST_MUL;
                end
                else if ($signed(de) < $signed(ssp_pkg::NEG_TOL_NS))
                begin
                    half2_next = 1'b1;
                    mag_next = de[47] ? (48'd0 - de) : de;
                    cur_accel_next = up_v ? 32'd0 - accel_limit_reg : accel_limit_reg;
                    neg_next = up_v ? (!de[47] && de != 48'd0) : de[47];
                    x_next = {80'd0, dl_v};
                    y_next = {16'd0, dl_v};
                    z_next = 128'd0;
                    step_next = ssp_pkg::STP_DD;
                    state_next = ssp_pkg::ST_MUL;
                end
                else
                begin
                    // Step completes: snap to the target and count it.
                    f_step_next = 1'b1;
                    cur_rate_next = 32'd0;
                    cur_angle_next = to_reg;
                    start_time_next = end_time_reg;
                    done_v = up_v ? done_reg + 16'd1 : done_reg - 16'd1;
                    done_next = done_v;
                    abs_pos_next = up_v ? abs_pos_reg + 32'd1 : abs_pos_reg - 32'd1;
                    if (done_v == cmd_reg && !f_intr_reg)
                    begin
                        f_act_next = 1'b1;
                    end
                    state_next = ssp_pkg::ST_OUT;
                end
            end

            ssp_pkg::ST_MUL:
            begin
                // Shift-add multiply, one multiplier bit a cycle.
                if (y_reg == 64'd0)
                begin
                    state_next = ssp_pkg::ST_NEXT;
                end
                else
                begin
                    if (y_reg[0])
                    begin
                        z_next = add_sum[127:0];
                    end
                    x_next = {x_reg[126:0], 1'b0};
                    y_next = {1'b0, y_reg[63:1]};
                end
            end

            ssp_pkg::ST_RND:
            begin
                // Add half the divisor for round to nearest.
                x_next = add_sum[127:0];
                state_next = ssp_pkg::ST_DIV;
            end

            ssp_pkg::ST_DIV:
            begin
                // Restoring divide, one quotient bit a cycle.
                if (add_sum[128])
                begin
                    z_next = add_sum[127:0];
                    x_next = {x_reg[126:0], 1'b1};
                end
                else
                begin
                    z_next = rsh;
                    x_next = {x_reg[126:0], 1'b0};
                end
                if (cnt_reg == 7'd0)
                begin
                    state_next = ssp_pkg::ST_NEXT;
                end
                else
                begin
                    cnt_next = cnt_reg - 7'd1;
                end
            end

            ssp_pkg::ST_NEXT:
            begin
                // Take the finished result and load the following operation.
                z_next = 128'd0;
                cnt_next = 7'h7F;
                case (step_reg)
                    ssp_pkg::STP_DD:
                    begin
                        dd_next = z_reg[95:0];
                        x_next = {80'd0, mag_reg};
                        y_next = {16'd0, mag_reg};
                        step_next = ssp_pkg::STP_MM;
                        state_next = ssp_pkg::ST_MUL;
                    end
                    ssp_pkg::STP_MM:
                    begin
                        x_next = z_reg;
                        y_next = {31'd0, sl_reg, 1'b0};
                        step_next = ssp_pkg::STP_NA;
                        state_next = ssp_pkg::ST_MUL;
                    end
                    ssp_pkg::STP_NA:
                    begin
                        x_next = z_reg;
                        w_next = {32'd0, dd_reg};
                        step_next = ssp_pkg::STP_ANG;
                        state_next = ssp_pkg::ST_RND;
                    end
                    ssp_pkg::STP_ANG:
                    begin
                        ang_next = ang_q;
                        x_next = {96'd0, sl_reg};
                        y_next = {16'd0, mag_reg};
                        step_next = ssp_pkg::STP_SM;
                        state_next = ssp_pkg::ST_MUL;
                    end
                    ssp_pkg::STP_SM:
                    begin
                        x_next = z_reg;
                        y_next = ssp_pkg::NS_PER_S;
                        step_next = ssp_pkg::STP_NR;
                        state_next = ssp_pkg::ST_MUL;
                    end
                    ssp_pkg::STP_NR:
                    begin
                        x_next = z_reg;
                        w_next = {30'd0, dd_reg, 2'b00};
                        step_next = ssp_pkg::STP_RATE;
                        state_next = ssp_pkg::ST_RND;
                    end
                    ssp_pkg::STP_RATE:
                    begin
                        cur_rate_next = neg_reg ? 32'd0 - rate_q : rate_q;
                        if (half2_reg)
                        begin
                            cur_angle_next = up_reg ? to_reg - ang_reg : to_reg + ang_reg;
                        end
                        else
                        begin
                            cur_angle_next = up_reg ? from_reg + ang_reg : from_reg - ang_reg;
                        end
                        state_next = ssp_pkg::ST_OUT;
                    end
                    ssp_pkg::STP_POS:
                    begin
                        abs_pos_next = neg_reg ? 32'd0 - ang_q : ang_q;
                        state_next = ssp_pkg::ST_IDLE;
                    end
                    ssp_pkg::STP_ACD:
                    begin
                        dd_next = z_reg[95:0];
                        x_next = {97'd0, step_angle_reg};
                        y_next = ssp_pkg::E18;
                        step_next = ssp_pkg::STP_ACN;
                        state_next = ssp_pkg::ST_MUL;
                    end
                    ssp_pkg::STP_ACN:
                    begin
                        x_next = z_reg;
                        w_next = {22'd0, dd_reg, 10'd0};
                        step_next = ssp_pkg::STP_ACL;
                        state_next = ssp_pkg::ST_RND;
                    end
                    ssp_pkg::STP_ACL:
                    begin
                        accel_limit_next = rate_q;
                        state_next = ssp_pkg::ST_IDLE;
                    end
                    default:
                    begin
                        state_next = ssp_pkg::ST_IDLE;
                    end
                endcase
            end

            ssp_pkg::ST_OUT:
            begin
                // Load the output register once it is free.
                if (!m_tvalid_reg || m_tready)
                begin
                    out_next = {7'd0, moving_reg, abs_pos_reg, done_reg, cmd_reg,
                                cur_accel_reg, cur_rate_reg, cur_angle_reg};
                    m_tvalid_next = 1'b1;
                    state_next = ssp_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ssp_pkg::ST_IDLE;
            end
        endcase

        // Configuration writes; a write to any of the three registers queues an acceleration limit recompute.
        if (cfg_we)
        begin
            case (cfg_addr)
                ssp_pkg::REG_STEP_ANGLE:
                begin
                    step_angle_next = cfg_data[30:0];
                    pend_acc_next = 1'b1;
                end
                ssp_pkg::REG_STEP_DURATION:
                begin
                    step_duration_next = cfg_data;
                    pend_acc_next = 1'b1;
                end
                ssp_pkg::REG_START_ANGLE:
                begin
                    cur_angle_next = cfg_data;
                    seg_base_next = cfg_data;
                    pos_start_next = cfg_data;
                    pos_sa_next = step_angle_reg;
                    pend_pos_next = 1'b1;
                    pend_acc_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ssp_pkg::ST_IDLE;
            step_reg <= ssp_pkg::STP_DD;
            step_angle_reg <= ssp_pkg::STEP_ANGLE_RST;
            step_duration_reg <= ssp_pkg::STEP_DURATION_RST;
            cur_angle_reg <= 32'd0;
            cur_rate_reg <= 32'd0;
            cur_accel_reg <= 32'd0;
            accel_limit_reg <= ssp_pkg::ACCEL_LIMIT_RST;
            seg_base_reg <= 32'd0;
            from_reg <= 32'd0;
            to_reg <= 32'd0;
            start_time_reg <= 48'd0;
            mid_time_reg <= 48'd0;
            end_time_reg <= 48'd0;
            cmd_reg <= 16'd0;
            done_reg <= 16'd0;
            abs_pos_reg <= 32'd0;
            f_act_reg <= 1'b1;
            f_step_reg <= 1'b1;
            f_new_reg <= 1'b0;
            f_intr_reg <= 1'b0;
            moving_reg <= 1'b0;
            pend_pos_reg <= 1'b0;
            pend_acc_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
            step_angle_reg <= step_angle_next;
            step_duration_reg <= step_duration_next;
            cur_angle_reg <= cur_angle_next;
            cur_rate_reg <= cur_rate_next;
            cur_accel_reg <= cur_accel_next;
            accel_limit_reg <= accel_limit_next;
            seg_base_reg <= seg_base_next;
            from_reg <= from_next;
            to_reg <= to_next;
            start_time_reg <= start_time_next;
            mid_time_reg <= mid_time_next;
            end_time_reg <= end_time_next;
            cmd_reg <= cmd_next;
            done_reg <= done_next;
            abs_pos_reg <= abs_pos_next;
            f_act_reg <= f_act_next;
            f_step_reg <= f_step_next;
            f_new_reg <= f_new_next;
            f_intr_reg <= f_intr_next;
            moving_reg <= moving_next;
            pend_pos_reg <= pend_pos_next;
            pend_acc_reg <= pend_acc_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Datapath working registers.
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        t_reg <= t_next;
        up_reg <= up_next;
        neg_reg <= neg_next;
        half2_reg <= half2_next;
        sl_reg <= sl_next;
        dl_reg <= dl_next;
        mag_reg <= mag_next;
        dd_reg <= dd_next;
        ang_reg <= ang_next;
        pos_start_reg <= pos_start_next;
        pos_sa_reg <= pos_sa_next;
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        w_reg <= w_next;
        cnt_reg <= cnt_next;
    end

    // An accepted beat keeps the block busy on the next cycle.
    `SSP_ASSERT(a_busy_after_accept, s_accept |=> !s_tready)
    // The last divide step always hands over to the result step.
    `SSP_ASSERT(a_div_ends, (state_reg == ssp_pkg::ST_DIV && cnt_reg == 7'd0) |=> (state_reg == ssp_pkg::ST_NEXT))
    // A new output beat only comes out of the output state.
    `SSP_ASSERT(a_out_source, $rose(m_tvalid_reg) |-> $past(state_reg == ssp_pkg::ST_OUT))

endmodule
`default_nettype wire
